### sv/mf3_pkg.sv
// shared constants and types of the 3x3 median filter
`timescale 1ns / 1ps

package mf3_pkg;

  localparam int CFG_W = 10;
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 10'd512;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 10'd512;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_PIXEL_BITS = 8;

  localparam int WIN_SIZE = 9;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // results pending for one window
  typedef struct packed {
    logic valid;
    logic emit1;
    logic last1;
    logic emit2;
    logic eof2;
  } stage_t;

endpackage

### sv/mf3_window.sv
// line stores, row and column counters and the 3x3 window register
`timescale 1ns / 1ps

module mf3_window #(
  parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = mf3_pkg::DEF_PIXEL_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic                          command,
  input  logic [PIXEL_BITS-1:0]         pixel_in,
  input  logic [mf3_pkg::CFG_W-1:0]     width_in_use,
  input  logic [mf3_pkg::CFG_W-1:0]     height_in_use,
  input  logic                          b_take,
  output mf3_pkg::stage_t               b,
  output logic [9*PIXEL_BITS-1:0]       win
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int WA = $clog2(MAX_WIDTH + 1);
  localparam int HA = $clog2(MAX_HEIGHT + 1);
  localparam int WW = (mf3_pkg::CFG_W > WA) ? mf3_pkg::CFG_W : WA;
  localparam int HW = (mf3_pkg::CFG_W > HA) ? mf3_pkg::CFG_W : HA;

  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic          draining;

  logic [PIXEL_BITS-1:0] line_store_upper [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] line_store_middle [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] up_rd;
  logic [PIXEL_BITS-1:0] mid_rd;

  logic                  a_valid;
  logic [PIXEL_BITS-1:0] a_pix;
  logic [CW-1:0]         a_col;
  logic                  a_first;
  logic                  a_have_up;
  logic                  a_have_mid;
  logic                  a_emit1;
  logic                  a_last1;
  logic                  a_emit2;
  logic                  a_eof2;

  logic [PIXEL_BITS-1:0] window_regs [9];
  logic [PIXEL_BITS-1:0] window_next [9];
  logic [PIXEL_BITS-1:0] base [9];

  logic [WW-1:0] w_reg;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_reg;
  logic [HW-1:0] h_eff;
  logic [WW-1:0] col_inc;
  logic [HW-1:0] row_inc;
  logic          last_col;
  logic          have_row;
  logic          have_up;
  logic          accept;
  logic          take;
  logic          a_move;

  always_comb begin
    w_reg = WW'(width_in_use);
    if (w_reg < WW'(2)) begin
      w_eff = WW'(2);
    end else if (w_reg > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_reg;
    end
    h_reg = HW'(height_in_use);
    if (h_reg < HW'(1)) begin
      h_eff = HW'(1);
    end else if (h_reg > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = h_reg;
    end
  end

  assign col_inc  = WW'(column_count) + WW'(1);
  assign row_inc  = HW'(row_count) + HW'(1);
  assign last_col = col_inc >= w_eff;
  assign have_row = HW'(row_count) >= HW'(1);
  assign have_up  = HW'(row_count) >= HW'(2);

  assign a_move   = a_valid && (!b.valid || b_take);
  assign s_tready = !a_valid || a_move;
  assign accept   = s_tvalid && s_tready;
  // a word whose kind does not match the drain state is dropped
  assign take     = accept && (command == draining);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      draining     <= 1'b0;
    end else if (take) begin
      if (last_col) begin
        column_count <= '0;
        if (draining) begin
          row_count <= '0;
          draining  <= 1'b0;
        end else begin
          row_count <= RW'(row_inc);
          if (row_inc >= h_eff) begin
            draining <= 1'b1;
          end
        end
      end else begin
        column_count <= col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (take) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_pix      <= draining ? '0 : pixel_in;
      a_col      <= column_count;
      a_first    <= column_count == '0;
      a_have_up  <= have_up;
      a_have_mid <= have_row;
      a_emit1    <= have_row && (column_count != '0);
      a_last1    <= !last_col;
      a_emit2    <= have_row && last_col;
      a_eof2     <= draining;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      up_rd <= line_store_upper[column_count];
    end
    if (a_move) begin
      line_store_upper[a_col] <= mid_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mid_rd <= line_store_middle[column_count];
    end
    if (a_move) begin
      line_store_middle[a_col] <= a_pix;
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      base[i] = a_first ? '0 : window_regs[i];
    end
    window_next[0] = base[1];
    window_next[1] = base[2];
    window_next[2] = a_have_up ? up_rd : '0;
    window_next[3] = base[4];
    window_next[4] = base[5];
    window_next[5] = a_have_mid ? mid_rd : '0;
    window_next[6] = base[7];
    window_next[7] = base[8];
    window_next[8] = a_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        window_regs[i] <= '0;
      end
    end else if (a_move) begin
      window_regs <= window_next;
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      win[i*PIXEL_BITS +: PIXEL_BITS] = window_regs[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b <= '0;
    end else if (a_move) begin
      b <= '{valid: 1'b1, emit1: a_emit1, last1: a_last1, emit2: a_emit2, eof2: a_eof2};
    end else if (b_take) begin
      b.valid <= 1'b0;
    end
  end

  ap_hold_full: assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_move |-> !s_tready)
    else $error("word taken while input stage is held");

  ap_port_apart: assert property (@(posedge clk) disable iff (rst)
    a_move && take |-> a_col != column_count)
    else $error("line store read and write hit the same column");

endmodule

### sv/mf3_median.sv
// two-stage median-of-nine compare-exchange network
`timescale 1ns / 1ps

module mf3_median #(
  parameter int PIXEL_BITS = mf3_pkg::DEF_PIXEL_BITS
) (
  input  logic                    clk,
  input  logic                    ld,
  input  logic [9*PIXEL_BITS-1:0] win,
  output logic [PIXEL_BITS-1:0]   med
);

  localparam int PW = PIXEL_BITS;

  logic [PW-1:0] p [9];
  logic [PW-1:0] rows [9];
  logic [PW-1:0] q [9];

  // returns {larger, smaller}
  function automatic logic [2*PW-1:0] cx(input logic [PW-1:0] x, input logic [PW-1:0] y);
    return (x > y) ? {x, y} : {y, x};
  endfunction

  // each row sorted
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      p[i] = win[i*PW +: PW];
    end
    {p[2], p[1]} = cx(p[1], p[2]);
    {p[5], p[4]} = cx(p[4], p[5]);
    {p[8], p[7]} = cx(p[7], p[8]);
    {p[1], p[0]} = cx(p[0], p[1]);
    {p[4], p[3]} = cx(p[3], p[4]);
    {p[7], p[6]} = cx(p[6], p[7]);
    {p[2], p[1]} = cx(p[1], p[2]);
    {p[5], p[4]} = cx(p[4], p[5]);
    {p[8], p[7]} = cx(p[7], p[8]);
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      rows <= p;
    end
  end

  // max of mins, median of medians, min of maxes
  always_comb begin
    q = rows;
    {q[3], q[0]} = cx(q[0], q[3]);
    {q[8], q[5]} = cx(q[5], q[8]);
    {q[7], q[4]} = cx(q[4], q[7]);
    {q[6], q[3]} = cx(q[3], q[6]);
    {q[4], q[1]} = cx(q[1], q[4]);
    {q[5], q[2]} = cx(q[2], q[5]);
    {q[7], q[4]} = cx(q[4], q[7]);
    {q[2], q[4]} = cx(q[4], q[2]);
    {q[4], q[6]} = cx(q[6], q[4]);
    {q[2], q[4]} = cx(q[4], q[2]);
    med = q[4];
  end

endmodule

### sv/mf3_out_fifo.sv
// four-entry result queue taking up to two words per cycle
`timescale 1ns / 1ps

module mf3_out_fifo #(
  parameter int PIXEL_BITS = mf3_pkg::DEF_PIXEL_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_a,
  input  logic [PIXEL_BITS+1:0] data_a,
  input  logic                  push_b,
  input  logic [PIXEL_BITS+1:0] data_b,
  output logic                  room,
  output logic                  head_valid,
  output logic [PIXEL_BITS+1:0] head,
  input  logic                  pop
);

  logic [PIXEL_BITS+1:0]         mem [mf3_pkg::FIFO_DEPTH];
  logic [mf3_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [mf3_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [mf3_pkg::FIFO_CNT_W-1:0] count;
  logic [mf3_pkg::FIFO_CNT_W-1:0] n_push;
  logic                           do_pop;

  assign room       = count <= mf3_pkg::FIFO_CNT_W'(mf3_pkg::FIFO_DEPTH - 2);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;
  assign n_push     = mf3_pkg::FIFO_CNT_W'(push_a) + mf3_pkg::FIFO_CNT_W'(push_b);

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem[wr_ptr] <= data_a;
    end
    if (push_b) begin
      mem[wr_ptr + mf3_pkg::FIFO_PTR_W'(1)] <= data_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[mf3_pkg::FIFO_PTR_W-1:0];
      if (do_pop) begin
        rd_ptr <= rd_ptr + mf3_pkg::FIFO_PTR_W'(1);
      end
      count <= count + n_push - mf3_pkg::FIFO_CNT_W'(do_pop);
    end
  end

  ap_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= mf3_pkg::FIFO_CNT_W'(mf3_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  ap_pair_order: assert property (@(posedge clk) disable iff (rst)
    push_b |-> push_a && room)
    else $error("second word pushed without first or without room");

endmodule

### sv/median_filter_3x3.sv
// top level of the 3x3 median filter
`timescale 1ns / 1ps

// Grey pixels enter on the s_ stream in raster order, one word per pixel,
// s_tuser low. After the last row of a frame the source sends one row of
// drain words (s_tuser high) that stand for the zero row below the frame.
// A word whose kind does not match the current phase is taken and dropped.
// Each result leaves on the m_ stream: m_tdata is the median, m_tlast marks
// the last result caused by one input word, m_tuser marks the bottom-right
// pixel of the frame. The first row gives no results; in later rows the
// first word gives none, the last word gives two and every other word one.
// Throughput is one input word per cycle while m_tready is high: a row of
// width W gives W results, so the output side keeps pace and the queue
// absorbs the pair at row end. An accepted word loads the input register
// and line store read, then the window register, the median stage split and
// the result queue in turn. Row width and frame height are written on
// the wr_ port by the user, only while idle; the block does not enforce it.
// Reset clears counters, window and queue; line stores keep their contents.
// When m_tready is low the result queue fills, then s_tready drops.

module median_filter_3x3 #(
  parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = mf3_pkg::DEF_PIXEL_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // pixel_in
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]     s_tdata,
  // command
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // median_pixel
  output logic [((PIXEL_BITS+7)/8)*8-1:0]     m_tdata,
  output logic                                m_tlast,
  // end_of_frame
  output logic                                m_tuser,
  input  logic                                wr_en,
  input  logic [mf3_pkg::REG_IDX_W-1:0]       wr_index,
  input  logic [mf3_pkg::CFG_W-1:0]           wr_data
);

  localparam int PW   = PIXEL_BITS;
  localparam int TD_W = ((PIXEL_BITS + 7) / 8) * 8;

  logic [mf3_pkg::CFG_W-1:0] width_in_use;
  logic [mf3_pkg::CFG_W-1:0] height_in_use;

  mf3_pkg::stage_t b;
  mf3_pkg::stage_t c;
  logic [9*PW-1:0] win;
  logic [9*PW-1:0] win2;
  logic [PW-1:0]   med1;
  logic [PW-1:0]   med2;
  logic            b_take;
  logic            c_take;
  logic            room;
  logic            push_a;
  logic            push_b;
  logic [PW+1:0]   data_a;
  logic [PW+1:0]   data_b;
  logic [PW+1:0]   head;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use  <= mf3_pkg::WIDTH_RESET;
      height_in_use <= mf3_pkg::HEIGHT_RESET;
    end else if (wr_en) begin
      case (wr_index)
        mf3_pkg::REG_WIDTH:  width_in_use  <= wr_data;
        mf3_pkg::REG_HEIGHT: height_in_use <= wr_data;
        default: ;
      endcase
    end
  end

  mf3_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .command       (s_tuser),
    .pixel_in      (s_tdata[PW-1:0]),
    .width_in_use  (width_in_use),
    .height_in_use (height_in_use),
    .b_take        (b_take),
    .b             (b),
    .win           (win)
  );

  // right-edge window: one more shift with the zero column past the edge
  always_comb begin
    win2 = '0;
    for (int r = 0; r < 3; r++) begin
      win2[(3*r)*PW +: PW]   = win[(3*r+1)*PW +: PW];
      win2[(3*r+1)*PW +: PW] = win[(3*r+2)*PW +: PW];
    end
  end

  assign c_take = c.valid && room;
  assign b_take = b.valid && (!c.valid || c_take);

  always_ff @(posedge clk) begin
    if (rst) begin
      c <= '0;
    end else if (b_take) begin
      c <= b;
    end else if (c_take) begin
      c.valid <= 1'b0;
    end
  end

  mf3_median #(.PIXEL_BITS(PIXEL_BITS)) u_med_inner (
    .clk (clk),
    .ld  (b_take),
    .win (win),
    .med (med1)
  );

  mf3_median #(.PIXEL_BITS(PIXEL_BITS)) u_med_edge (
    .clk (clk),
    .ld  (b_take),
    .win (win2),
    .med (med2)
  );

  // queue word: {median, last, eof}
  assign push_a = c_take && (c.emit1 || c.emit2);
  assign push_b = c_take && c.emit1 && c.emit2;
  assign data_b = {med2, 1'b1, c.eof2};
  assign data_a = c.emit1 ? {med1, c.last1, 1'b0} : data_b;

  mf3_out_fifo #(.PIXEL_BITS(PIXEL_BITS)) u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_a     (push_a),
    .data_a     (data_a),
    .push_b     (push_b),
    .data_b     (data_b),
    .room       (room),
    .head_valid (m_tvalid),
    .head       (head),
    .pop        (m_tready)
  );

  assign m_tdata = TD_W'(head[PW+1:2]);
  assign m_tlast = head[1];
  assign m_tuser = head[0];

endmodule
